>>> hw/rtl/ecse_pkg.sv
// ecse_pkg: widths, register indexes and the speed scale factor shared by the
// encoder count and speed estimator. Depends on nothing.
`timescale 1ns / 1ps
package ecse_pkg;

	localparam int POS_W       = 16;             // position count and config registers
	localparam int CFG_W       = 16;             // widest configuration register
	localparam int CFG_INDEX_W = 1;              // register index width
	localparam int STEP_W      = 18;             // corrected count step, signed
	localparam int DIFF_W      = 17;             // raw count difference, signed
	localparam int MAG_W       = 27;             // |step| * 625
	localparam int DIVIDEND_W  = 25;             // |step| * 625 / 4
	localparam int SPEED_W     = 26;             // speed result, signed
	localparam int SCALE       = 625;            // 156.25 * 4

	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_LIMIT     = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_THRESHOLD = 1'b1;

	localparam logic [POS_W-1:0] WRAP_LIMIT_RESET     = 16'hFFFF;
	localparam logic [POS_W-1:0] WRAP_THRESHOLD_RESET = 16'h8000;

	typedef logic [POS_W-1:0]               pos_t;
	typedef logic signed [STEP_W-1:0]       step_t;
	typedef logic signed [DIFF_W-1:0]       diff_t;
	typedef logic [DIVIDEND_W-1:0]          dividend_t;
	typedef logic signed [SPEED_W-1:0]      speed_t;

endpackage

>>> hw/rtl/encoder_count_speed_estimator_unit.sv
// encoder_count_speed_estimator_unit: quadrature position counter with a
// bit-serial interval speed estimator. Depends on ecse_pkg.
`timescale 1ns / 1ps
// An edge request (command 0) moves the position count one step, up when
// b_level is 1 and down when it is 0, wrapping between 0 and wrap_limit. It
// is taken when idle and the result slot is free, and posts its result at once.
// A sample request (command 1) forms the count step since the previous sample,
// corrects it by wrap_limit when the jump reaches wrap_threshold, and reports
// speed = step * 625 / (4 * dt), truncated toward zero, where dt is the time
// since the previous sample modulo 2^TIME_BITS. A sample steps from acceptance
// to result as follows: latch the count difference and interval, correct the
// step, scale it by 625, run the restoring divider over the DIVIDEND_W (25)
// dividend bits, one quotient bit per cycle, and load the result register once
// it is free. A zero interval skips the divider and raises zero_interval with
// speed 0. One request is in flight at a time; a new sample request may be
// accepted while the previous result still waits in the output register.
// Configuration writes are taken in any cycle but must only occur while idle.
module encoder_count_speed_estimator_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [ecse_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ecse_pkg::CFG_W-1:0]        cfg_wdata,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic                              b_level,
	input  logic [31:0]                       time_ms,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ecse_pkg::POS_W-1:0]        position_out,
	output logic signed [ecse_pkg::SPEED_W-1:0] speed,
	output logic                              speed_valid,
	output logic                              zero_interval
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_STEP  = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam int CNT_W = $clog2(ecse_pkg::DIVIDEND_W);

	// Control and state
	logic [2:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       out_valid_q;
	ecse_pkg::pos_t             wrap_limit_q;
	ecse_pkg::pos_t             wrap_threshold_q;
	ecse_pkg::pos_t             position_q;
	ecse_pkg::pos_t             last_count_q;
	logic [TIME_BITS-1:0]       last_time_q;

	// Sample datapath
	ecse_pkg::diff_t            diff_s1;
	logic [TIME_BITS-1:0]       dt_q;
	logic                       zero_q;
	ecse_pkg::step_t            step_s2;
	logic                       neg_q;
	ecse_pkg::dividend_t        quo_q;       // dividend shifts out, quotient shifts in
	logic [TIME_BITS-1:0]       rem_q;

	// Result register
	ecse_pkg::pos_t             pos_out_q;
	ecse_pkg::speed_t           speed_q;
	logic                       speed_valid_q;
	logic                       zero_out_q;

	logic                       out_free;
	logic                       accept;
	logic                       post_result;
	logic [TIME_BITS+31:0]      time_wide;
	logic [TIME_BITS-1:0]       now;
	ecse_pkg::pos_t             pos_next;
	logic [ecse_pkg::POS_W-1:0] abs_diff;
	logic                       wrap_hit;
	ecse_pkg::step_t            diff_ext;
	ecse_pkg::step_t            lim_ext;
	ecse_pkg::step_t            step_c;
	logic [ecse_pkg::STEP_W-2:0] step_abs;
	logic [ecse_pkg::MAG_W-1:0] mag;
	logic [TIME_BITS:0]         trial;
	logic [TIME_BITS:0]         dt_ext;
	logic [TIME_BITS:0]         trial_diff;
	logic                       fits;
	ecse_pkg::speed_t           speed_c;

	assign out_free = !out_valid_q || out_ready;
	// A sample needs no free result slot to start; an edge finishes at once.
	assign in_ready = (state_q == ST_IDLE) && (command || out_free);
	assign accept   = in_valid && in_ready;

	// Load the result register on an accepted edge or a finished sample.
	assign post_result = (state_q == ST_IDLE && accept && !command)
		|| (state_q == ST_DONE && out_free);

	// Widen or trim the millisecond time to the interval width.
	assign time_wide = {{TIME_BITS{1'b0}}, time_ms};
	assign now       = time_wide[TIME_BITS-1:0];

	// Edge counting with wrap at both ends.
	always_comb begin
		if (b_level) begin
			pos_next = (position_q >= wrap_limit_q) ? '0 : position_q + 1'b1;
		end else begin
			pos_next = (position_q == '0) ? wrap_limit_q : position_q - 1'b1;
		end
	end

	// Step correction: the count is stable while a sample is in flight.
	always_comb begin
		abs_diff = diff_s1[ecse_pkg::DIFF_W-1] ? ecse_pkg::POS_W'(-diff_s1)
			: diff_s1[ecse_pkg::POS_W-1:0];
		wrap_hit = abs_diff >= wrap_threshold_q;
		diff_ext = ecse_pkg::STEP_W'(diff_s1);
		lim_ext  = ecse_pkg::step_t'({2'b00, wrap_limit_q});
		if (!wrap_hit) begin
			step_c = diff_ext;
		end else if (position_q > wrap_threshold_q) begin
			step_c = diff_ext - lim_ext;
		end else begin
			step_c = diff_ext + lim_ext;
		end
	end

	// Scale magnitude by 625; the divide by 4 is the dropped low bits.
	assign step_abs = step_s2[ecse_pkg::STEP_W-1] ? (ecse_pkg::STEP_W-1)'(-step_s2)
		: step_s2[ecse_pkg::STEP_W-2:0];
	assign mag = ecse_pkg::MAG_W'(step_abs) * ecse_pkg::MAG_W'(ecse_pkg::SCALE);

	// One restoring division step.
	assign trial      = {rem_q, quo_q[ecse_pkg::DIVIDEND_W-1]};
	assign dt_ext     = {1'b0, dt_q};
	assign trial_diff = trial - dt_ext;
	assign fits       = trial >= dt_ext;

	always_comb begin
		if (zero_q) begin
			speed_c = '0;
		end else if (neg_q) begin
			speed_c = -ecse_pkg::speed_t'({1'b0, quo_q});
		end else begin
			speed_c = ecse_pkg::speed_t'({1'b0, quo_q});
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q     <= ecse_pkg::WRAP_LIMIT_RESET;
			wrap_threshold_q <= ecse_pkg::WRAP_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecse_pkg::REG_WRAP_LIMIT:     wrap_limit_q     <= cfg_wdata;
				ecse_pkg::REG_WRAP_THRESHOLD: wrap_threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			position_q   <= '0;
			last_count_q <= '0;
			last_time_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Post a new result, or drop the slot once its result is taken.
			out_valid_q <= post_result || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !command) begin
						// Edge: count and post the result right away.
						position_q <= pos_next;
					end else if (accept) begin
						last_count_q <= position_q;
						last_time_q  <= now;
						state_q      <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					cnt_q   <= CNT_W'(ecse_pkg::DIVIDEND_W - 1);
					state_q <= zero_q ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && command) begin
			diff_s1 <= ecse_pkg::diff_t'({1'b0, position_q})
				- ecse_pkg::diff_t'({1'b0, last_count_q});
			dt_q    <= now - last_time_q;
		end
		if (state_q == ST_STEP) begin
			step_s2 <= step_c;
			zero_q  <= dt_q == '0;
		end
		if (state_q == ST_SCALE) begin
			neg_q <= step_s2[ecse_pkg::STEP_W-1];
			quo_q <= mag[ecse_pkg::MAG_W-1:2];
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			// Shift in the next dividend bit; subtract when the divisor fits.
			rem_q <= fits ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[ecse_pkg::DIVIDEND_W-2:0], fits};
		end
		if (state_q == ST_IDLE && accept && !command) begin
			pos_out_q     <= pos_next;
			speed_q       <= '0;
			speed_valid_q <= 1'b0;
			zero_out_q    <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			pos_out_q     <= position_q;
			speed_q       <= speed_c;
			speed_valid_q <= !zero_q;
			zero_out_q    <= zero_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign position_out  = pos_out_q;
	assign speed         = speed_q;
	assign speed_valid   = speed_valid_q;
	assign zero_interval = zero_out_q;

	// A result never claims both a speed and a zero interval.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(speed_valid_q && zero_out_q))
		else $error("speed_valid and zero_interval both set");

	// A result without a speed sample carries zero speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !speed_valid_q) |-> (speed_q == '0))
		else $error("nonzero speed without speed_valid");

	// The count moves only on an accepted edge: it holds while a sample is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(position_q))
		else $error("position changed while a sample was in flight");

	// A result is posted only when the slot frees up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> (state_q == ST_DONE))
		else $error("sample left the done state with the result slot full");

	// The divider count stays within the quotient width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_W'(ecse_pkg::DIVIDEND_W - 1)))
		else $error("divider count out of range");

endmodule

>>> sim/tb.sv
// tb: self-checking bench for encoder_count_speed_estimator_unit. Drives edge and
// sample requests, predicts every result and compares it field by field.
// Depends on ecse_pkg and the unit under test.
`timescale 1ns / 1ps
module tb;

	localparam logic CMD_EDGE   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;
	localparam logic B_DOWN     = 1'b0;
	localparam logic B_UP       = 1'b1;

	localparam int DIRECTED_ROWS    = 24;
	localparam int PHASES           = 8;
	localparam int ITEMS_PER_PHASE  = 195;
	localparam int QUIET_LIMIT      = 5000;  // cycles without any transfer
	localparam int TAIL_CYCLES      = 40;    // a bit over one sample's latency

	typedef struct packed {
		ecse_pkg::pos_t   pos;
		ecse_pkg::speed_t spd;
		logic             spd_valid;
		logic             zero_dt;
	} encoder_result_t;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                        kind;
		logic                             cmd;
		logic                             b;
		logic [31:0]                      t;
		logic [ecse_pkg::CFG_INDEX_W-1:0] reg_index;
		logic [ecse_pkg::CFG_W-1:0]       reg_value;
		logic                             typed;    // result below is the known answer
		encoder_result_t                  result;
	} stim_row_t;

	localparam encoder_result_t NO_RESULT = '0;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ecse_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [ecse_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic b_level = 1'b0;
	logic [31:0] time_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ecse_pkg::pos_t position_out;
	ecse_pkg::speed_t speed;
	logic speed_valid;
	logic zero_interval;

	encoder_count_speed_estimator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.b_level      (b_level),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position_out (position_out),
		.speed        (speed),
		.speed_valid  (speed_valid),
		.zero_interval(zero_interval)
	);

	// Predictor state, mirrored from the block's registers.
	ecse_pkg::pos_t count_q       = '0;
	ecse_pkg::pos_t sampled_count = '0;
	logic [31:0]    sampled_time  = '0;
	ecse_pkg::pos_t limit_q       = ecse_pkg::WRAP_LIMIT_RESET;
	ecse_pkg::pos_t thresh_q      = ecse_pkg::WRAP_THRESHOLD_RESET;

	encoder_result_t pending_results [$];
	encoder_result_t predicted, want;
	logic            typed_pending = 1'b0;
	encoder_result_t typed_result  = '0;
	int              mismatch_count = 0;
	int              quiet_cycles   = 0;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;

	// Advance the mirrored counter by one request and return what the block should report.
	function automatic encoder_result_t advance_encoder(input logic cmd, input logic b,
			input logic [31:0] t);
		encoder_result_t r;
		longint cur, prev, lim, thr, diff, jump, step, num, mag, quot;
		logic [31:0] dt;
		r = '0;
		if (cmd == CMD_EDGE) begin
			if (b == B_UP)
				count_q = (count_q >= limit_q) ? ecse_pkg::pos_t'(0) : count_q + 1'b1;
			else
				count_q = (count_q == '0) ? limit_q : count_q - 1'b1;
		end else begin
			cur  = count_q;
			prev = sampled_count;
			lim  = limit_q;
			thr  = thresh_q;
			diff = cur - prev;
			jump = (diff < 0) ? -diff : diff;
			// A large jump means the count wrapped: fold it back by the limit.
			if (jump >= thr)
				step = (cur > thr) ? cur - lim - prev : cur + lim - prev;
			else
				step = diff;
			dt = t - sampled_time;
			if (dt == '0) begin
				r.zero_dt = 1'b1;
			end else begin
				num  = step * ecse_pkg::SCALE;
				mag  = (num < 0) ? -num : num;
				quot = (mag / 4) / longint'({32'd0, dt});
				r.spd = (num < 0) ? ecse_pkg::speed_t'(-quot) : ecse_pkg::speed_t'(quot);
				r.spd_valid = 1'b1;
			end
			sampled_count = count_q;
			sampled_time  = t;
		end
		r.pos = count_q;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Check results, predict on each accepted request, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with nothing pending: pos %0d speed %0d", $time,
						position_out, speed);
				end else begin
					want = pending_results.pop_front();
					if (position_out !== want.pos) begin
						mismatch_count++;
						$display("%0t: position_out expected %0d got %0d", $time, want.pos,
							position_out);
					end
					if (speed !== want.spd) begin
						mismatch_count++;
						$display("%0t: speed expected %0d got %0d", $time, want.spd, speed);
					end
					if (speed_valid !== want.spd_valid) begin
						mismatch_count++;
						$display("%0t: speed_valid expected %0b got %0b", $time,
							want.spd_valid, speed_valid);
					end
					if (zero_interval !== want.zero_dt) begin
						mismatch_count++;
						$display("%0t: zero_interval expected %0b got %0b", $time,
							want.zero_dt, zero_interval);
					end
				end
			end
			if (in_valid && in_ready) begin
				predicted = advance_encoder(command, b_level, time_ms);
				pending_results.push_back(typed_pending ? typed_result : predicted);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Drop valid and hold until every pending result is out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ecse_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ecse_pkg::CFG_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			ecse_pkg::REG_WRAP_LIMIT:     limit_q  = val;
			ecse_pkg::REG_WRAP_THRESHOLD: thresh_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Present one request and hold it until accepted; starts and ends at a falling edge.
	task automatic send_request(input logic cmd, input logic b, input logic [31:0] t,
			input logic typed, input encoder_result_t res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		typed_pending = typed;
		typed_result  = res;
		in_valid <= 1'b1;
		command  <= cmd;
		b_level  <= b;
		time_ms  <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	stim_row_t      directed_rows [DIRECTED_ROWS];
	ecse_pkg::pos_t phase_limit, phase_thresh;
	logic [31:0]    sample_ms;
	int             up_pct;

	initial begin
		directed_rows = '{
			// sample right after reset: zero interval
			'{ROW_REQUEST, CMD_SAMPLE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'd0, 26'sd0, 1'b0, 1'b1}},
			// count down through zero, then back up through the limit
			'{ROW_REQUEST, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'hFFFF, 26'sd0, 1'b0, 1'b0}},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'd0, 26'sd0, 1'b0, 1'b0}},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'hFFFF_FFFF, ecse_pkg::REG_WRAP_LIMIT, 16'd0,
				1'b0, NO_RESULT},
			// widest interval, then the time wrapping around
			'{ROW_REQUEST, CMD_SAMPLE, B_UP, 32'hFFFF_FFFF, ecse_pkg::REG_WRAP_LIMIT, 16'd0,
				1'b0, NO_RESULT},
			'{ROW_REQUEST, CMD_SAMPLE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			// backward wrap folds into a step of -1
			'{ROW_REQUEST, CMD_SAMPLE, B_DOWN, 32'd1, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'hFFFF, -26'sd156, 1'b1, 1'b0}},
			'{ROW_REQUEST, CMD_SAMPLE, B_UP, 32'd1, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'hFFFF, 26'sd0, 1'b0, 1'b1}},
			// highest threshold: largest positive step
			'{ROW_WRITE, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_THRESHOLD, 16'hFFFF,
				1'b0, NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'hFFFF_FFFF, ecse_pkg::REG_WRAP_LIMIT, 16'd0,
				1'b0, NO_RESULT},
			'{ROW_REQUEST, CMD_SAMPLE, B_UP, 32'd2, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_SAMPLE, B_DOWN, 32'd3, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'hFFFF, 26'sd20479687, 1'b1, 1'b0}},
			// zero threshold: every sample folds, largest negative step
			'{ROW_WRITE, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_THRESHOLD, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_SAMPLE, B_DOWN, 32'd4, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'd1, -26'sd20479531, 1'b1, 1'b0}},
			// zero limit below the count: up wraps to zero, then the count sticks
			'{ROW_WRITE, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_DOWN, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_EDGE, B_UP, 32'd0, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b0,
				NO_RESULT},
			'{ROW_REQUEST, CMD_SAMPLE, B_UP, 32'd4, ecse_pkg::REG_WRAP_LIMIT, 16'd0, 1'b1,
				'{16'd0, 26'sd0, 1'b0, 1'b1}}
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
			else
				send_request(directed_rows[i].cmd, directed_rows[i].b, directed_rows[i].t,
					directed_rows[i].typed, directed_rows[i].result);
		end

		sample_ms = 32'd4;
		up_pct    = 50;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin phase_limit = 16'hFFFF; phase_thresh = 16'h8000; end
				1: begin phase_limit = 16'd1; phase_thresh = 16'd1; end
				2: begin
					phase_limit  = ecse_pkg::pos_t'($urandom_range(2, 300));
					phase_thresh = ecse_pkg::pos_t'($urandom_range(1, phase_limit));
				end
				3: begin phase_limit = 16'hFFFF; phase_thresh = 16'hFFFF; end
				4: begin
					phase_limit  = ecse_pkg::pos_t'($urandom_range(3, 40));
					phase_thresh = 16'd0;
				end
				5: begin
					phase_limit  = ecse_pkg::pos_t'($urandom);
					phase_thresh = ecse_pkg::pos_t'($urandom);
				end
				6: begin
					phase_limit  = ecse_pkg::pos_t'($urandom_range(1000, 60000));
					phase_thresh = phase_limit / 2;
				end
				default: begin phase_limit = 16'hFFFF; phase_thresh = 16'd1; end
			endcase
			write_reg(ecse_pkg::REG_WRAP_LIMIT, phase_limit);
			write_reg(ecse_pkg::REG_WRAP_THRESHOLD, phase_thresh);
			// Rotate through quiet, sender gaps, receiver stalls and both together.
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					drain_results();
				// Drift the direction now and then so the count runs across the wrap.
				if ($urandom_range(0, 49) == 0)
					up_pct = $urandom_range(10, 90);
				if ($urandom_range(0, 99) < 28) begin
					case ($urandom_range(0, 9))
						0: ;  // same time again: zero interval
						1: sample_ms += $urandom_range(51, 100000);
						2: sample_ms = $urandom;
						default: sample_ms += $urandom_range(1, 50);
					endcase
					send_request(CMD_SAMPLE, 1'($urandom_range(0, 1)), sample_ms, 1'b0,
						NO_RESULT);
				end else begin
					send_request(CMD_EDGE, ($urandom_range(0, 99) < up_pct) ? B_UP : B_DOWN,
						$urandom, 1'b0, NO_RESULT);
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> encoder_count_speed_estimator_unit.f
hw/rtl/ecse_pkg.sv
hw/rtl/encoder_count_speed_estimator_unit.sv
sim/tb.sv
